FILE: hw/rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg - shared types and constants of the beat-tweened LED segment
// Item layouts, command queue entry and the back-end sequencer states.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int VAL_W       = 16;  // Q0.16 position / size
    localparam int BEAT_W      = 24;  // Q16.8 beat
    localparam int FRAC_W      = 8;   // fraction bits of a beat
    localparam int SPAN_W      = 8;   // whole beats
    localparam int LEN_W       = SPAN_W + FRAC_W;
    localparam int PROD_W      = VAL_W + LEN_W;
    localparam int DIV_STEPS   = VAL_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int FUNC_W      = 2;
    localparam int IDX_OUT_W   = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_POS  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_SIZE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BEAT_W-1:0] beat;
        logic [VAL_W-1:0]  target;
        logic [SPAN_W-1:0] span_beats;
    } t_in_item;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] led_index;
        logic                 lit;
        logic                 last;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_SET_POS  = 2'd1,
        KIND_SET_SIZE = 2'd2
    } t_kind;

    // Queue entry: span already forced to at least one beat
    typedef struct packed {
        t_kind             kind;
        logic [BEAT_W-1:0] beat;
        logic [VAL_W-1:0]  target;
        logic [SPAN_W-1:0] span;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_PROD,
        ST_DIV,
        ST_FIN,
        ST_SCALE,
        ST_BOUND,
        ST_EMIT
    } t_state;

endpackage

FILE: hw/rtl/bts_stream_if.sv
// ----------------------------------------------------------------------------
// bts_stream_if - valid/ready stream channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface bts_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bts_front.sv
// ----------------------------------------------------------------------------
// bts_front - input decode
// Classify incoming items, repair zero spans and drop unused function codes.
// ----------------------------------------------------------------------------
module bts_front (
    bts_stream_if.sink         i_in,
    input  logic               i_q_full,
    output logic               o_push,
    output bts_pkg::t_cmd      o_cmd
);
    import bts_pkg::*;

    logic w_known;

    assign i_in.ready = !i_q_full;

    always_comb begin
        w_known    = 1'b1;
        o_cmd.kind = KIND_TICK;
        unique case (i_in.data.func)
            FUNC_TICK:     o_cmd.kind = KIND_TICK;
            FUNC_SET_POS:  o_cmd.kind = KIND_SET_POS;
            FUNC_SET_SIZE: o_cmd.kind = KIND_SET_SIZE;
            default:       w_known    = 1'b0;
        endcase
        o_cmd.beat   = i_in.data.beat;
        o_cmd.target = i_in.data.target;
        o_cmd.span   = (i_in.data.span_beats == '0) ? SPAN_W'(1) : i_in.data.span_beats;
    end

    // Drop unused codes at the door: accepted, never queued
    assign o_push = i_in.valid && !i_q_full && w_known;

endmodule

FILE: hw/rtl/bts_fifo.sv
// ----------------------------------------------------------------------------
// bts_fifo - command queue
// Short queue between decode and execution.
// ----------------------------------------------------------------------------
module bts_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bts_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bts_pkg::t_cmd o_cmd
);
    import bts_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_Q-1:0] r_count;
    logic             w_do_pop;

    assign o_full   = (r_count == CNT_Q'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_cmd    = r_mem[r_rptr];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + CNT_Q'(1);
            end else if (w_do_pop && !i_push) begin
                r_count <= r_count - CNT_Q'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/bts_back.sv
// ----------------------------------------------------------------------------
// bts_back - tween engine and pixel emitter
// Apply set commands, interpolate position and size on a tick through one
// shared multiply / serial divide unit, then stream one result per LED.
// ----------------------------------------------------------------------------
module bts_back #(
    parameter int LED_COUNT = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  bts_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    bts_stream_if.source  o_out
);
    import bts_pkg::*;

    localparam int IDX_W = $clog2(LED_COUNT);
    localparam int BW    = IDX_W + 2;
    localparam int SC_W  = VAL_W + IDX_W;

    // Tween state, position and size
    logic [VAL_W-1:0]  r_pos_start, r_pos_dest, r_pos_now;
    logic [BEAT_W-1:0] r_pos_begin;
    logic [SPAN_W-1:0] r_pos_span;
    logic [VAL_W-1:0]  r_size_start, r_size_dest, r_size_now;
    logic [BEAT_W-1:0] r_size_begin;
    logic [SPAN_W-1:0] r_size_span;
    logic [VAL_W-1:0]  n_pos_start, n_pos_dest, n_pos_now;
    logic [BEAT_W-1:0] n_pos_begin;
    logic [SPAN_W-1:0] n_pos_span;
    logic [VAL_W-1:0]  n_size_start, n_size_dest, n_size_now;
    logic [BEAT_W-1:0] n_size_begin;
    logic [SPAN_W-1:0] n_size_span;

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    // Scratch
    logic              r_sel, n_sel;
    logic [BEAT_W-1:0] r_beat, n_beat;
    logic [LEN_W-1:0]  r_e, n_e;
    logic [VAL_W-1:0]  r_dist, n_dist;
    logic              r_up, n_up;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [VAL_W-1:0]  r_rem, n_rem;
    logic [VAL_W-1:0]  r_lo, n_lo;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_lp, n_lp, r_ls, n_ls;
    logic signed [BW-1:0] r_lower, n_lower, r_upper, n_upper;
    logic [IDX_W-1:0]  r_idx, n_idx;

    // Selected channel
    logic [VAL_W-1:0]  w_start, w_dest;
    logic [BEAT_W-1:0] w_begin;
    logic [SPAN_W-1:0] w_span;
    logic [LEN_W-1:0]  w_len;
    logic [BEAT_W:0]   w_end;
    logic [PROD_W-1:0] w_prod;
    logic [VAL_W:0]    w_trial;
    logic              w_qbit;
    logic [SC_W-1:0]   w_sc_pos, w_sc_size;
    logic [IDX_W:0]    w_half_up;
    logic              w_now_we, w_chan_done, w_take;
    logic [VAL_W-1:0]  w_now_val;
    logic signed [BW-1:0] w_i;

    assign w_start = r_sel ? r_size_start : r_pos_start;
    assign w_dest  = r_sel ? r_size_dest  : r_pos_dest;
    assign w_begin = r_sel ? r_size_begin : r_pos_begin;
    assign w_span  = r_sel ? r_size_span  : r_pos_span;
    assign w_len   = {w_span, {FRAC_W{1'b0}}};
    assign w_end   = {1'b0, w_begin} + (BEAT_W + 1)'(w_len);

    assign w_prod    = PROD_W'(r_dist) * PROD_W'(r_e);
    assign w_trial   = {r_rem, r_lo[VAL_W-1]};
    assign w_qbit    = (w_trial >= {1'b0, r_len});
    assign w_sc_pos  = SC_W'(LED_COUNT - 1) * SC_W'(r_pos_now);
    assign w_sc_size = SC_W'(LED_COUNT - 1) * SC_W'(r_size_now);
    assign w_half_up = ({1'b0, r_ls} + (IDX_W + 1)'(1)) >> 1;
    assign w_i       = $signed({2'b00, r_idx});
    assign w_take    = !r_out_valid || o_out.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_pos_start  = r_pos_start;
        n_pos_dest   = r_pos_dest;
        n_pos_now    = r_pos_now;
        n_pos_begin  = r_pos_begin;
        n_pos_span   = r_pos_span;
        n_size_start = r_size_start;
        n_size_dest  = r_size_dest;
        n_size_now   = r_size_now;
        n_size_begin = r_size_begin;
        n_size_span  = r_size_span;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        n_sel        = r_sel;
        n_beat       = r_beat;
        n_e          = r_e;
        n_dist       = r_dist;
        n_up         = r_up;
        n_len        = r_len;
        n_rem        = r_rem;
        n_lo         = r_lo;
        n_cnt        = r_cnt;
        n_lp         = r_lp;
        n_ls         = r_ls;
        n_lower      = r_lower;
        n_upper      = r_upper;
        n_idx        = r_idx;
        o_q_pop      = 1'b0;
        w_now_we     = 1'b0;
        w_now_val    = w_start;
        w_chan_done  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.kind)
                        KIND_SET_POS: begin
                            n_pos_start = r_pos_now;
                            n_pos_dest  = i_q_cmd.target;
                            n_pos_begin = i_q_cmd.beat;
                            n_pos_span  = i_q_cmd.span;
                        end
                        KIND_SET_SIZE: begin
                            n_size_start = r_size_now;
                            n_size_dest  = i_q_cmd.target;
                            n_size_begin = i_q_cmd.beat;
                            n_size_span  = i_q_cmd.span;
                        end
                        KIND_TICK: begin
                            n_beat  = i_q_cmd.beat;
                            n_sel   = 1'b0;
                            n_state = ST_CMP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP: begin
                priority if ({1'b0, r_beat} > w_end) begin
                    w_now_we    = 1'b1;
                    w_now_val   = w_dest;
                    w_chan_done = 1'b1;
                end else if (r_beat < w_begin) begin
                    w_now_we    = 1'b1;
                    w_now_val   = w_start;
                    w_chan_done = 1'b1;
                end else begin
                    n_e     = LEN_W'(r_beat - w_begin);
                    n_up    = (w_dest >= w_start);
                    n_dist  = (w_dest >= w_start) ? (w_dest - w_start) : (w_start - w_dest);
                    n_len   = w_len;
                    n_state = ST_PROD;
                end
            end
            ST_PROD: begin
                n_rem   = w_prod[PROD_W-1:VAL_W];
                n_lo    = w_prod[VAL_W-1:0];
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = w_qbit ? VAL_W'(w_trial - {1'b0, r_len}) : w_trial[VAL_W-1:0];
                n_lo  = {r_lo[VAL_W-2:0], w_qbit};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                w_now_we    = 1'b1;
                w_now_val   = r_up ? (w_start + r_lo) : (w_start - r_lo);
                w_chan_done = 1'b1;
            end
            ST_SCALE: begin
                n_lp    = w_sc_pos[SC_W-1:VAL_W];
                n_ls    = w_sc_size[SC_W-1:VAL_W];
                n_state = ST_BOUND;
            end
            ST_BOUND: begin
                n_lower = $signed(BW'(r_lp)) - $signed(BW'(w_half_up));
                n_upper = $signed(BW'(r_lp)) + $signed(BW'(r_ls >> 1));
                n_idx   = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_take) begin
                    n_out_valid     = 1'b1;
                    n_out.led_index = IDX_OUT_W'(r_idx);
                    n_out.lit       = (w_i >= r_lower) && (w_i <= r_upper);
                    n_out.last      = (r_idx == IDX_W'(LED_COUNT - 1));
                    if (r_idx == IDX_W'(LED_COUNT - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_now_we) begin
            if (r_sel) begin
                n_size_now = w_now_val;
            end else begin
                n_pos_now = w_now_val;
            end
        end
        // Position first, then size, then scale
        if (w_chan_done) begin
            if (r_sel) begin
                n_state = ST_SCALE;
            end else begin
                n_sel   = 1'b1;
                n_state = ST_CMP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_pos_start  <= '0;
            r_pos_dest   <= '0;
            r_pos_now    <= '0;
            r_pos_begin  <= '0;
            r_pos_span   <= SPAN_W'(1);
            r_size_start <= '0;
            r_size_dest  <= '0;
            r_size_now   <= '0;
            r_size_begin <= '0;
            r_size_span  <= SPAN_W'(1);
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_pos_start  <= n_pos_start;
            r_pos_dest   <= n_pos_dest;
            r_pos_now    <= n_pos_now;
            r_pos_begin  <= n_pos_begin;
            r_pos_span   <= n_pos_span;
            r_size_start <= n_size_start;
            r_size_dest  <= n_size_dest;
            r_size_now   <= n_size_now;
            r_size_begin <= n_size_begin;
            r_size_span  <= n_size_span;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_sel   <= n_sel;
        r_beat  <= n_beat;
        r_e     <= n_e;
        r_dist  <= n_dist;
        r_up    <= n_up;
        r_len   <= n_len;
        r_rem   <= n_rem;
        r_lo    <= n_lo;
        r_cnt   <= n_cnt;
        r_lp    <= n_lp;
        r_ls    <= n_ls;
        r_lower <= n_lower;
        r_upper <= n_upper;
        r_idx   <= n_idx;
    end

endmodule

FILE: hw/rtl/beat_tweened_led_segment.sv
// ----------------------------------------------------------------------------
// beat_tweened_led_segment - beat-timed LED segment renderer
// Glide a lit segment's position and size toward their targets over a span
// of beats and stream one lit/dark result per LED on every tick.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                              | per transfer
//   --------+-----+--------------------------------------+----------------------
//   i_in    | in  | func, beat, target, span_beats       | one command
//   o_out   | out | led_index, lit, last                 | one LED of a frame
//
// A set command is applied as it is dequeued. A tick is dequeued, then each
// channel is interpolated (compare, multiply, 16-step restoring divide,
// finish, once for position and once for size; a channel whose glide is over
// or not yet begun settles in its compare cycle), then scaled and bounded,
// then output one LED per cycle while o_out is ready. The sequencer takes no
// new command until the frame's last LED is taken into the output register.
// Reset is synchronous, active low; it clears the queue, the sequencer and
// the tween state (spans return to one beat).
// A stall on o_out freezes only the emitter; up to two commands still queue.
//
module beat_tweened_led_segment #(
    parameter int LED_COUNT = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bts_stream_if.sink   i_in,
    bts_stream_if.source o_out
);
    import bts_pkg::*;

    logic w_push, w_full, w_q_valid, w_pop;
    t_cmd w_cmd_in, w_cmd_out;

    // Decode: classify the transfer, repair the span, drop unused codes
    bts_front u_front (
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    // Hold commands so decode and execution stall independently
    bts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out)
    );

    // Execute: update targets, interpolate, scale, emit the frame
    bts_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_cmd_out),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );

endmodule

FILE: hw/rtl/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker - port-level checks of the LED segment renderer
// Watch the result stream for frame ordering and reset behaviour.
// ----------------------------------------------------------------------------
module bts_checker #(
    parameter int LED_COUNT = 64
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [5:0] i_led_index,
    input logic       i_lit,
    input logic       i_last
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_led_index) && $stable(i_lit) && $stable(i_last))
        else $error("stalled result changed");

    // Advance by one LED after each non-final transfer, with no gap
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=>
            i_out_valid && (i_led_index == $past(i_led_index) + 6'd1))
        else $error("frame not contiguous");

    // Mark the last LED and no other; stay inside the strip
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_led_index <= 6'(LED_COUNT - 1)) &&
            (i_last == (i_led_index == 6'(LED_COUNT - 1))))
        else $error("bad last flag or index");

    // Drop results on reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind beat_tweened_led_segment bts_checker #(
    .LED_COUNT (LED_COUNT)
) u_bts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_led_index (o_out.data.led_index),
    .i_lit       (o_out.data.lit),
    .i_last      (o_out.data.last)
);
